// ----- src/b64d_pkg.sv -----
// b64d_pkg: shared types, codes and character helpers for the base64 decoder.
// Used by b64d_step and base64_strict_decoder; no dependencies of its own.
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int COUNT_WIDTH_DEF = 17;
    localparam int CAP_W           = 16;
    localparam int BYTE_COUNT_W    = 17;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // classify() codes beyond the 6-bit alphabet values
    localparam logic [6:0] CLS_PAD = 7'd64;
    localparam logic [6:0] CLS_BAD = 7'd65;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_SHORT   = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } char_t;

    typedef struct packed {
        logic [7:0]              out_byte;
        logic                    byte_valid;
        logic [BYTE_COUNT_W-1:0] byte_count;
        status_t                 status;
        logic                    final_res;
    } result_t;

    typedef struct packed {
        logic       pad_mode;
        logic [1:0] group_index;
        logic [5:0] bit_accum;
        logic       error_seen;
    } dec_state_t;

    typedef struct packed {
        logic       have_octet;
        logic [7:0] octet;
    } dec_out_t;

    function automatic logic [6:0] classify(input logic [7:0] c);
        logic [6:0] v;
        begin
            if (c inside {[8'h41:8'h5A]})
                v = 7'(c - 8'h41);
            else if (c inside {[8'h61:8'h7A]})
                v = 7'(c - 8'h61) + 7'd26;
            else if (c inside {[8'h30:8'h39]})
                v = 7'(c - 8'h30) + 7'd52;
            else if (c == 8'h2B)
                v = 7'd62;
            else if (c == 8'h2F)
                v = 7'd63;
            else if (c == CHAR_PAD)
                v = CLS_PAD;
            else
                v = CLS_BAD;
            return v;
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {[8'h09:8'h0D], 8'h20});
    endfunction

endpackage

// ----- src/base64_strict_decoder.sv -----
// base64_strict_decoder: top level, input and result registers, octet count,
// capacity register. Depends on b64d_pkg and b64d_step.
//
// Usage:
//   char channel (char_valid / char_stall / char_data) takes one encoded
//   character per request, with in_last on the final character of a message.
//   res channel (res_valid / res_stall / res_data) returns exactly one
//   result per character: the decoded octet if one completed, the running
//   count, the status, and final_res on the closing result.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes dest_capacity; it
//   is always ready and is to be written only while the block is idle.
// Path: an accepted character is held in the input register, then its result is registered in the result register.
// Throughput: one character per clock while res_stall is low, set by the combinational decode step
//   between the input register and the result register.
// Reset: capacity returns to 65535 and message state clears; no result is
//   pending. After the last character, message state clears for the next one.
// Stall: while res_stall is high the result holds; one more character is
//   taken into the input register, then char_stall rises until the result
//   is taken.
`timescale 1ns / 1ps

module base64_strict_decoder #(
    parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       char_valid,
    output logic                       char_stall,
    input  b64d_pkg::char_t            char_data,
    output logic                       res_valid,
    input  logic                       res_stall,
    output b64d_pkg::result_t          res_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [b64d_pkg::CAP_W-1:0] cfg_data
);
    import b64d_pkg::*;

    localparam int WIDE_W = COUNT_WIDTH + CAP_W;

    logic                   in_full_reg;
    char_t                  in_item_reg;
    logic                   res_full_reg;
    result_t                res_item_reg;
    dec_state_t             dec_reg;
    dec_state_t             dec_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [CAP_W-1:0]       cap_reg;
    result_t                res_next;
    dec_out_t               dout;

    logic                   advance;
    logic                   accept_in;
    logic                   count_sat;
    logic                   fits;
    logic [WIDE_W-1:0]      count_wide;
    logic [WIDE_W-1:0]      count_next_wide;
    logic [WIDE_W-1:0]      cap_wide;
    logic [COUNT_WIDTH+BYTE_COUNT_W-1:0] count_out_ext;

    b64d_step u_step (
        .st      (dec_reg),
        .ch      (in_item_reg.in_char),
        .st_next (dec_next),
        .dout    (dout)
    );

    assign advance    = in_full_reg && (!res_full_reg || !res_stall);
    assign char_stall = in_full_reg && !advance;
    assign accept_in  = char_valid && !char_stall;
    assign cfg_ready  = 1'b1;
    assign res_valid  = res_full_reg;
    assign res_data   = res_item_reg;

    assign count_wide      = {{CAP_W{1'b0}}, count_reg};
    assign count_next_wide = {{CAP_W{1'b0}}, count_next};
    assign cap_wide        = {{COUNT_WIDTH{1'b0}}, cap_reg};
    assign count_sat       = (count_reg == {COUNT_WIDTH{1'b1}});
    assign fits            = (count_wide < cap_wide);
    assign count_next      = (dout.have_octet && !count_sat) ? count_reg + 1'b1 : count_reg;
    assign count_out_ext   = {{BYTE_COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        res_next            = '0;
        res_next.byte_valid = dout.have_octet && fits;
        res_next.out_byte   = res_next.byte_valid ? dout.octet : 8'd0;
        res_next.byte_count = count_out_ext[BYTE_COUNT_W-1:0];
        res_next.final_res  = in_item_reg.in_last;
        if (in_item_reg.in_last)
        begin
            if (dec_next.error_seen || dec_next.group_index != 2'd0)
                res_next.status = ST_INVALID;
            else if (count_next_wide > cap_wide)
                res_next.status = ST_SHORT;
            else
                res_next.status = ST_OK;
        end
        else
        begin
            res_next.status = dec_next.error_seen ? ST_INVALID : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            res_full_reg <= 1'b0;
            dec_reg      <= '0;
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
        end
        else
        begin
            if (accept_in)
                in_full_reg <= 1'b1;
            else if (advance)
                in_full_reg <= 1'b0;

            if (advance)
                res_full_reg <= 1'b1;
            else if (!res_stall)
                res_full_reg <= 1'b0;

            if (advance)
            begin
                if (in_item_reg.in_last)
                begin
                    dec_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    dec_reg   <= dec_next;
                    count_reg <= count_next;
                end
            end

            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
            in_item_reg <= char_data;
        if (advance)
            res_item_reg <= res_next;
    end

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.in_last |=> count_reg == '0 && dec_reg == '0)
        else $error("message state not cleared after last character");

    a_byte_zero_when_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.byte_valid |-> res_data.out_byte == 8'd0)
        else $error("out_byte nonzero without byte_valid");

    a_byte_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.byte_valid && !res_data.final_res
            |-> res_data.status == ST_OK)
        else $error("octet emitted after an error");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_full_reg |-> !char_stall)
        else $error("input stalled with empty input register");

    a_short_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status == ST_SHORT |-> res_data.final_res)
        else $error("buffer-too-small status on a non-final result");
`endif

endmodule

// ----- src/b64d_step.sv -----
// b64d_step: one character of decode, from current group state to next.
// Depends on b64d_pkg for the state types and character classification.
`timescale 1ns / 1ps

module b64d_step (
    input  b64d_pkg::dec_state_t st,
    input  logic [7:0]           ch,
    output b64d_pkg::dec_state_t st_next,
    output b64d_pkg::dec_out_t   dout
);
    import b64d_pkg::*;

    logic [6:0] cls;
    logic [5:0] v;

    assign cls = classify(ch);
    assign v   = cls[5:0];

    always_comb
    begin
        st_next = st;
        dout    = '0;
        if (!st.error_seen && !is_space(ch))
        begin
            if (st.pad_mode)
            begin
                if (ch == CHAR_PAD && st.group_index == 2'd3)
                    st_next.group_index = 2'd0;
                else
                    st_next.error_seen = 1'b1;
            end
            else if (cls == CLS_PAD)
            begin
                st_next.pad_mode = 1'b1;
                if (st.group_index == 2'd2)
                    st_next.group_index = 2'd3;
                else if (st.group_index == 2'd3)
                    st_next.group_index = 2'd0;
                else
                    st_next.error_seen = 1'b1;
                if (st.bit_accum != 6'd0)
                    st_next.error_seen = 1'b1;
            end
            else if (cls == CLS_BAD)
            begin
                st_next.error_seen = 1'b1;
            end
            else
            begin
                st_next.group_index = st.group_index + 2'd1;
                case (st.group_index)
                    2'd0:
                    begin
                        st_next.bit_accum = v;
                    end
                    2'd1:
                    begin
                        dout.octet        = {st.bit_accum, v[5:4]};
                        dout.have_octet   = 1'b1;
                        st_next.bit_accum = {2'b00, v[3:0]};
                    end
                    2'd2:
                    begin
                        dout.octet        = {st.bit_accum[3:0], v[5:2]};
                        dout.have_octet   = 1'b1;
                        st_next.bit_accum = {4'b0000, v[1:0]};
                    end
                    default:
                    begin
                        dout.octet        = {st.bit_accum[1:0], v};
                        dout.have_octet   = 1'b1;
                        st_next.bit_accum = 6'd0;
                    end
                endcase
            end
        end
    end

endmodule

// ----- dv/tb.sv -----
// tb: self-checking bench for base64_strict_decoder, one encoded character per request.
// Random and directed character streams run against an in-bench decode predictor.
// Depends on b64d_pkg and the base64_strict_decoder RTL.
`timescale 1ns / 1ps

module tb;

    import b64d_pkg::*;

    localparam int  LIMIT        = 1000000;
    localparam int  BURST_GROUPS = 25;
    localparam int  COUNT_TOP    = (1 << BYTE_COUNT_W) - 1;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             char_valid = 1'b0;
    logic             char_stall;
    char_t            char_data = '0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    result_t          res_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data = '0;

    char_t            char_stream[$];
    result_t          decode_results[$];
    int               n_offered = 0;
    int               n_taken = 0;
    int               idle_pct = 22;
    int               errors = 0;
    int               cycles = 0;

    logic [CAP_W-1:0]        capacity = CAP_RESET;
    logic                    pad_on = 1'b0;
    logic [1:0]              grp = '0;
    logic [5:0]              carry = '0;
    logic                    err = 1'b0;
    logic [BYTE_COUNT_W-1:0] octets = '0;

    base64_strict_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 26)
            return 8'h41 + 8'(v);
        else if (v < 52)
            return 8'h61 + 8'(v - 26);
        else if (v < 62)
            return 8'h30 + 8'(v - 52);
        else if (v == 62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(5))
            0: return 8'h09;
            1: return 8'h0A;
            2: return 8'h0B;
            3: return 8'h0C;
            4: return 8'h0D;
            default: return 8'h20;
        endcase
    endfunction

    task automatic decode_char(input char_t c, output result_t r);
        logic [6:0]  sym;
        logic [11:0] acc;
        logic [7:0]  oct;
        logic        got;
        logic        fits;
        logic [7:0]  ch;
        ch   = c.in_char;
        got  = 1'b0;
        fits = 1'b0;
        oct  = '0;
        if (!err && !(ch inside {[8'h09:8'h0D], 8'h20}))
        begin
            if (ch >= 8'h41 && ch <= 8'h5A)
                sym = 7'(ch - 8'h41);
            else if (ch >= 8'h61 && ch <= 8'h7A)
                sym = 7'(ch - 8'h61) + 7'd26;
            else if (ch >= 8'h30 && ch <= 8'h39)
                sym = 7'(ch - 8'h30) + 7'd52;
            else if (ch == 8'h2B)
                sym = 7'd62;
            else if (ch == 8'h2F)
                sym = 7'd63;
            else if (ch == CHAR_PAD)
                sym = CLS_PAD;
            else
                sym = CLS_BAD;
            if (pad_on)
            begin
                if (ch == CHAR_PAD && grp == 2'd3)
                    grp = 2'd0;
                else
                    err = 1'b1;
            end
            else if (sym == CLS_PAD)
            begin
                pad_on = 1'b1;
                if (grp == 2'd2)
                    grp = 2'd3;
                else if (grp == 2'd3)
                    grp = 2'd0;
                else
                    err = 1'b1;
                if (carry != 0)
                    err = 1'b1;
            end
            else if (sym == CLS_BAD)
                err = 1'b1;
            else
            begin
                acc = {carry, sym[5:0]};
                grp = grp + 2'd1;
                case (grp)
                    2'd1: carry = acc[5:0];
                    2'd2:
                    begin
                        oct   = acc[11:4];
                        carry = {2'b00, acc[3:0]};
                        got   = 1'b1;
                    end
                    2'd3:
                    begin
                        oct   = acc[9:2];
                        carry = {4'b0000, acc[1:0]};
                        got   = 1'b1;
                    end
                    default:
                    begin
                        oct   = acc[7:0];
                        carry = '0;
                        got   = 1'b1;
                    end
                endcase
            end
        end
        if (got)
        begin
            fits = (octets < {1'b0, capacity});
            if (octets != COUNT_TOP)
                octets = octets + 1'b1;
        end
        r.out_byte   = fits ? oct : 8'h00;
        r.byte_valid = fits;
        r.byte_count = octets;
        r.final_res  = c.in_last;
        if (c.in_last)
        begin
            if (err || grp != 0)
                r.status = ST_INVALID;
            else if (octets > {1'b0, capacity})
                r.status = ST_SHORT;
            else
                r.status = ST_OK;
            pad_on = 1'b0;
            grp    = '0;
            carry  = '0;
            err    = 1'b0;
            octets = '0;
        end
        else
            r.status = err ? ST_INVALID : ST_OK;
    endtask

    // monitor: track accepted requests and check results at the rising edge
    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t fresh;
        cycles = cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (char_valid && !char_stall)
            begin
                decode_char(char_data, fresh);
                decode_results.push_back(fresh);
                n_taken = n_taken + 1;
            end
            if (res_valid && !res_stall)
            begin
                if (decode_results.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("unexpected result at %0t: %p", $realtime, res_data);
                end
                else
                begin
                    want = decode_results.pop_front();
                    if (res_data.out_byte !== want.out_byte
                        || res_data.byte_valid !== want.byte_valid
                        || res_data.byte_count !== want.byte_count
                        || res_data.status !== want.status
                        || res_data.final_res !== want.final_res)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("mismatch at %0t: expected %p, got %p",
                                     $realtime, want, res_data);
                    end
                end
            end
        end
    end

    // driver: present the next request once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n && n_taken == n_offered)
        begin
            if (char_stream.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                char_data  <= char_stream.pop_front();
                char_valid <= 1'b1;
                n_offered = n_offered + 1;
            end
            else
                char_valid <= 1'b0;
        end
        res_stall <= rst_n && ($urandom_range(99) < idle_pct);
    end

    task automatic push_char(input logic [7:0] c, input logic l);
        char_t t;
        t.in_char = c;
        t.in_last = l;
        char_stream.push_back(t);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (char_stream.size() != 0 || n_taken != n_offered
               || decode_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one message, well formed or broken, with stray whitespace
    task automatic add_message(input int nbytes, input int flaw);
        logic [7:0]  txt[$];
        logic [23:0] q;
        int          k;
        int          pos;
        for (int i = 0; i < nbytes; i += 3)
        begin
            k = (nbytes - i > 3) ? 3 : nbytes - i;
            q = 24'($urandom());
            if (k < 3)
                q[7:0] = '0;
            if (k < 2)
                q[15:8] = '0;
            txt.push_back(sextet_char(q[23:18]));
            txt.push_back(sextet_char(q[17:12]));
            txt.push_back(k >= 2 ? sextet_char(q[11:6]) : CHAR_PAD);
            txt.push_back(k == 3 ? sextet_char(q[5:0]) : CHAR_PAD);
        end
        case (flaw)
            1:
                if (txt.size() != 0)
                    txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
            2:
                if (txt.size() != 0)
                    void'(txt.pop_back());
            3:
            begin
                pos = -1;
                foreach (txt[i])
                    if (pos < 0 && txt[i] == CHAR_PAD)
                        pos = i;
                if (pos > 0)
                    txt[pos - 1] = sextet_char(6'($urandom()) | 6'd1);
            end
            4: txt.insert($urandom_range(txt.size()), CHAR_PAD);
            5:
            begin
                txt.delete();
                repeat ($urandom_range(1, 8))
                    txt.push_back(8'($urandom_range(255)));
            end
            default: ;
        endcase
        if (txt.size() == 0)
        begin
            push_char(blank_char(), 1'b1);
            return;
        end
        foreach (txt[i])
        begin
            if ($urandom_range(99) < 10)
                push_char(blank_char(), 1'b0);
            push_char(txt[i], 1'b0);
        end
        if ($urandom_range(99) < 85)
            char_stream[char_stream.size() - 1].in_last = 1'b1;
        else
            push_char(blank_char(), 1'b1);
    endtask

    initial
    begin : stimulus
        logic [CAP_W-1:0] caps[7];
        int               made;
        int               nb;
        caps[0] = 16'd0;
        caps[1] = 16'd1;
        caps[2] = 16'd3;
        caps[3] = CAP_RESET;
        caps[4] = 16'($urandom_range(60));
        caps[5] = 16'($urandom());
        caps[6] = 16'd17;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: normal, padded, bad pad, early pad, sticky error, blank last
        push_text("TW Fu\t");
        push_text("TQ=");
        push_text("TR==");
        push_text("Q=");
        push_text("+/9z");
        push_char("A", 1'b0);
        push_char(8'hFF, 1'b0);
        push_char("/", 1'b0);
        push_char(8'h00, 1'b1);
        drain();
        write_capacity(16'd1);
        push_text("TWFu");
        drain();

        foreach (caps[p])
        begin
            write_capacity(caps[p]);
            made = char_stream.size();
            while (char_stream.size() - made < 200)
            begin
                nb = ($urandom_range(99) < 90) ? $urandom_range(12) : $urandom_range(13, 40);
                add_message(nb, ($urandom_range(99) < 75) ? 0 : $urandom_range(1, 5));
            end
            drain();
        end

        // long run with no idling on either side
        write_capacity(CAP_RESET);
        idle_pct = 0;
        repeat (BURST_GROUPS)
            repeat (4)
                push_char(sextet_char(6'($urandom())), 1'b0);
        char_stream[char_stream.size() - 1].in_last = 1'b1;
        drain();
        idle_pct = 22;

        repeat (8) @(posedge clk);
        if (decode_results.size() != 0)
            errors = errors + 1;
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
